// ===== rtl/clearance_move_planner_assert.svh =====
// assertion macros for the clearance move planner
`ifndef CLEARANCE_MOVE_PLANNER_ASSERT_SVH
`define CLEARANCE_MOVE_PLANNER_ASSERT_SVH

`ifndef ASSERT_OFF
`define CMP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("clearance move planner assertion failed");
`define CMP_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("clearance move planner assertion failed");
`else
`define CMP_ASSERT(lbl, clk, rst_n, prop)
`define CMP_ASSERT_NR(lbl, clk, prop)
`endif

`endif

// ===== rtl/cmp_pkg.sv =====
// types and constants shared by the clearance move planner
`default_nettype none
package cmp_pkg;

  localparam int unsigned CLR_W     = 31;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned Q_DEPTH   = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_RETRACT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_APPROACH = 1'b1;

  localparam logic [CLR_W-1:0] RETRACT_RST  = 31'd327680;
  localparam logic [CLR_W-1:0] APPROACH_RST = 31'd65536;

  typedef enum logic [1:0] {
    KIND_DEPART   = 2'd0,
    KIND_TRANSFER = 2'd1,
    KIND_APPROACH = 2'd2,
    KIND_CUT      = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_ENTITY = 2'd1,
    ST_BAD_CFG    = 2'd2
  } status_e;

  typedef struct packed {
    logic [31:0]        id;
    status_e            status;
    logic               mv;
    logic               dep_valid;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] dz;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] sz;
    logic signed [31:0] zr;
    logic signed [31:0] za;
  } cmd_t;

  typedef struct packed {
    logic [31:0]        out_entity;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    kind_e              point_kind;
    status_e            status;
    logic               last;
  } out_item_t;

endpackage
`default_nettype wire

// ===== rtl/cmp_if.sv =====
// request channel interfaces for entities in and poses out
`default_nettype none
interface cmp_in_if;
  logic               valid;
  logic               ready;
  logic [31:0]        entity_id;
  logic signed [31:0] unit_index;
  logic signed [31:0] start_x;
  logic signed [31:0] start_y;
  logic signed [31:0] start_z;
  logic signed [31:0] end_x;
  logic signed [31:0] end_y;
  logic signed [31:0] end_z;

  modport source (output valid, entity_id, unit_index, start_x, start_y, start_z,
                  end_x, end_y, end_z, input ready);
  modport sink (input valid, entity_id, unit_index, start_x, start_y, start_z,
                end_x, end_y, end_z, output ready);
endinterface

interface cmp_out_if;
  logic               valid;
  logic               ready;
  logic [31:0]        out_entity;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic [1:0]         point_kind;
  logic [1:0]         status;
  logic               last;

  modport source (output valid, out_entity, pos_x, pos_y, pos_z, point_kind, status,
                  last, input ready);
  modport sink (input valid, out_entity, pos_x, pos_y, pos_z, point_kind, status,
                last, output ready);
endinterface
`default_nettype wire

// ===== rtl/cmp_front.sv =====
// front end: checks entities, tracks the previous unit and sums clearance heights
`default_nettype none
module cmp_front import cmp_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  cmp_in_if.sink                in_req,
  input  wire logic [CLR_W-1:0] retract_i,
  input  wire logic [CLR_W-1:0] approach_i,
  input  wire logic             q_full_i,
  output logic                  push_o,
  output cmd_t                  cmd_o
);

  localparam int unsigned SAT_W = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
  localparam logic signed [33:0] SatHi = 34'((64'sd1 <<< (SAT_W - 1)) - 64'sd1);
  localparam logic signed [33:0] SatLo = -SatHi - 34'sd1;

  function automatic logic [31:0] sat_add(logic [31:0] z, logic [CLR_W-1:0] c);
    logic signed [33:0] s;
    s = signed'({{2{z[31]}}, z}) + signed'({3'b000, c});
    if (s > SatHi) return SatHi[31:0];
    if (s < SatLo) return SatLo[31:0];
    return s[31:0];
  endfunction

  logic               have_prev_q, have_prev_d;
  logic signed [31:0] prev_unit_q, prev_unit_d;
  logic signed [31:0] prev_x_q, prev_x_d;
  logic signed [31:0] prev_y_q, prev_y_d;
  logic signed [31:0] prev_z_q, prev_z_d;

  logic    cfg_bad, ent_bad, mv;
  status_e status;

  assign in_req.ready = !q_full_i;
  assign push_o       = in_req.valid && !q_full_i;

  assign cfg_bad = (retract_i == '0) || (approach_i > retract_i);
  assign ent_bad = (in_req.entity_id == '0) || in_req.unit_index[31];
  assign mv      = !have_prev_q || (prev_unit_q != in_req.unit_index);

  always_comb begin
    if (cfg_bad) begin
      status = ST_BAD_CFG;
    end else if (ent_bad) begin
      status = ST_BAD_ENTITY;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    cmd_o.id        = in_req.entity_id;
    cmd_o.status    = status;
    cmd_o.mv        = mv;
    cmd_o.dep_valid = have_prev_q && mv;
    cmd_o.dx        = prev_x_q;
    cmd_o.dy        = prev_y_q;
    cmd_o.dz        = sat_add(prev_z_q, retract_i);
    cmd_o.sx        = in_req.start_x;
    cmd_o.sy        = in_req.start_y;
    cmd_o.sz        = in_req.start_z;
    cmd_o.zr        = sat_add(in_req.start_z, retract_i);
    cmd_o.za        = sat_add(in_req.start_z, approach_i);
    if (status != ST_OK) begin
      cmd_o.dx = '0;
      cmd_o.dy = '0;
      cmd_o.dz = '0;
    end
  end

  always_comb begin
    have_prev_d = have_prev_q;
    prev_unit_d = prev_unit_q;
    prev_x_d    = prev_x_q;
    prev_y_d    = prev_y_q;
    prev_z_d    = prev_z_q;
    if (push_o && status == ST_OK) begin
      have_prev_d = 1'b1;
      prev_unit_d = in_req.unit_index;
      prev_x_d    = in_req.end_x;
      prev_y_d    = in_req.end_y;
      prev_z_d    = in_req.end_z;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_prev_q <= 1'b0;
      prev_unit_q <= '0;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      prev_z_q    <= '0;
    end else begin
      have_prev_q <= have_prev_d;
      prev_unit_q <= prev_unit_d;
      prev_x_q    <= prev_x_d;
      prev_y_q    <= prev_y_d;
      prev_z_q    <= prev_z_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/cmp_fifo.sv =====
// short command queue between front and back end
`default_nettype none
module cmp_fifo import cmp_pkg::*; #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             pop_i,
  output logic                  full_o,
  output logic                  valid_o,
  output logic [WIDTH-1:0]      rdata_o
);

  localparam int unsigned PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned CNT_W = $clog2(Q_DEPTH + 1);

  logic [WIDTH-1:0] mem_q [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(Q_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/cmp_back.sv =====
// back end: drops repeated poses and issues one pose per cycle into the output register while the output is not stalled
`default_nettype none
module cmp_back import cmp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic q_valid_i,
  input  wire cmd_t q_cmd_i,
  output logic      pop_o,
  output logic      out_valid_o,
  output out_item_t out_item_o,
  input  wire logic out_ready_i
);

  function automatic logic [3:0] keep_mask(cmd_t c);
    logic eq10, eq21, eq32;
    eq10 = (c.sx == c.dx) && (c.sy == c.dy) && (c.zr == c.dz);
    eq21 = (c.za == c.zr);
    eq32 = (c.sz == c.za);
    if (c.status != ST_OK) return 4'b0001;
    return {!(c.mv && eq32), c.mv && !eq21, c.mv && !(c.dep_valid && eq10), c.dep_valid};
  endfunction

  cmd_t        cmd_q;
  logic [3:0]  mask_q, mask_d;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_q;
  kind_e       kind;
  logic [3:0]  onehot;
  logic        last, advance;
  logic signed [31:0] px, py, pz;

  always_comb begin
    if (mask_q[0]) begin
      kind = KIND_DEPART;
    end else if (mask_q[1]) begin
      kind = KIND_TRANSFER;
    end else if (mask_q[2]) begin
      kind = KIND_APPROACH;
    end else begin
      kind = KIND_CUT;
    end
  end

  always_comb begin
    unique case (kind)
      KIND_DEPART: begin
        px = cmd_q.dx; py = cmd_q.dy; pz = cmd_q.dz;
      end
      KIND_TRANSFER: begin
        px = cmd_q.sx; py = cmd_q.sy; pz = cmd_q.zr;
      end
      KIND_APPROACH: begin
        px = cmd_q.sx; py = cmd_q.sy; pz = cmd_q.za;
      end
      default: begin
        px = cmd_q.sx; py = cmd_q.sy; pz = cmd_q.sz;
      end
    endcase
  end

  assign onehot  = 4'b0001 << kind;
  assign last    = ((mask_q & ~onehot) == '0);
  assign advance = (mask_q != '0) && (!out_valid_q || out_ready_i);
  assign pop_o   = q_valid_i && ((mask_q == '0) || (advance && last));

  always_comb begin
    mask_d = mask_q;
    if (pop_o) begin
      mask_d = keep_mask(q_cmd_i);
    end else if (advance) begin
      mask_d = mask_q & ~onehot;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= q_cmd_i;
    end
    if (advance) begin
      out_q.out_entity <= cmd_q.id;
      out_q.pos_x      <= px;
      out_q.pos_y      <= py;
      out_q.pos_z      <= pz;
      out_q.point_kind <= kind;
      out_q.status     <= cmd_q.status;
      out_q.last       <= last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
`default_nettype wire

// ===== rtl/clearance_move_planner.sv =====
// clearance move planner top level: config registers, front end, queue, back end
// the first pose of an entity passes through the command queue, the back end command register and the output register
// throughput: one pose per cycle from the back end while the output is not stalled; an entity gives
// 1 to 4 poses, those left after repeated poses are dropped; errors give one pose
// the front end takes a new entity whenever the 2-entry command queue has room
// reset: asynchronous active low, clears history, queue, output valid, loads clearances
`default_nettype none
`include "clearance_move_planner_assert.svh"
module clearance_move_planner import cmp_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CLR_W-1:0]     cfg_wdata_i,
  cmp_in_if.sink                    in_req,
  cmp_out_if.source                 out_req
);

  logic [CLR_W-1:0] retract_q, retract_d, approach_q, approach_d;
  logic             push, q_full, q_valid, pop, out_valid;
  cmd_t             push_cmd, head_cmd;
  out_item_t        out_item;

  always_comb begin
    retract_d  = retract_q;
    approach_d = approach_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_RETRACT:  retract_d  = cfg_wdata_i;
        CFG_APPROACH: approach_d = cfg_wdata_i;
        default:      retract_d  = retract_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retract_q  <= RETRACT_RST;
      approach_q <= APPROACH_RST;
    end else begin
      retract_q  <= retract_d;
      approach_q <= approach_d;
    end
  end

  cmp_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_req     (in_req),
    .retract_i  (retract_q),
    .approach_i (approach_q),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  cmp_fifo #(.WIDTH($bits(cmd_t))) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_cmd),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .rdata_o (head_cmd)
  );

  cmp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_cmd_i     (head_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid),
    .out_item_o  (out_item),
    .out_ready_i (out_req.ready)
  );

  assign out_req.valid      = out_valid;
  assign out_req.out_entity = out_item.out_entity;
  assign out_req.pos_x      = out_item.pos_x;
  assign out_req.pos_y      = out_item.pos_y;
  assign out_req.pos_z      = out_item.pos_z;
  assign out_req.point_kind = out_item.point_kind;
  assign out_req.status     = out_item.status;
  assign out_req.last       = out_item.last;

  `CMP_ASSERT(a_err_single, clk_i, rst_ni, (out_req.valid && out_req.status != ST_OK) |-> (out_req.last && out_req.point_kind == KIND_DEPART))
  `CMP_ASSERT(a_cut_is_last, clk_i, rst_ni, (out_req.valid && !out_req.last) |-> (out_req.point_kind != KIND_CUT))
  `CMP_ASSERT(a_no_gap, clk_i, rst_ni, (out_req.valid && out_req.ready && !out_req.last) |=> out_req.valid)

endmodule
`default_nettype wire
